// ===== rtl/lzm_pkg.sv =====
// ----------------------------------------------------------------------------
// lzm_pkg
// Shared types and constants of the LZ77 longest-match encoder.
// ----------------------------------------------------------------------------
package lzm_pkg;

    localparam int BYTE_W = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_PUSH,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/lzm_byte_if.sv =====
// ----------------------------------------------------------------------------
// lzm_byte_if
// Input channel: one uncompressed byte per word, with an end-of-stream flag.
// ----------------------------------------------------------------------------
interface lzm_byte_if import lzm_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);

endinterface

// ===== rtl/lzm_token_if.sv =====
// ----------------------------------------------------------------------------
// lzm_token_if
// Output channel: one token per word (distance, length, literal, last flag).
// ----------------------------------------------------------------------------
interface lzm_token_if import lzm_pkg::*; #(
    parameter int DIST_W = 9,
    parameter int LEN_W  = 4
) ();

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] match_distance;
    logic [LEN_W-1:0]  match_length;
    logic [BYTE_W-1:0] next_literal;
    logic              token_last;

    modport source (
        output valid, output match_distance, output match_length,
        output next_literal, output token_last, input ready
    );
    modport sink (
        input valid, input match_distance, input match_length,
        input next_literal, input token_last, output ready
    );

endinterface

// ===== rtl/lz77_longest_match_encoder.sv =====
// ----------------------------------------------------------------------------
// lz77_longest_match_encoder
// LZ77 encoder: exhaustive longest-match search over a sliding history.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte takes one byte per word; in_last marks the final byte of a stream.
//   o_token gives one token per word: backward distance, match length, the
//   literal that follows, and token_last on the final token of a stream.
//   Bytes collect in a lookahead of LOOKAHEAD_SIZE bytes. A full lookahead
//   (or in_last) starts a token; in_last flushes tokens until it is empty,
//   then history and lookahead restart empty for the next stream.
//   For each token the HF history bytes (HF is the history fill, up to
//   WINDOW_SIZE) are read one byte per cycle into a compare window, then
//   the lookahead bytes; one start position is scored per cycle, then
//   LEN+1 bytes, LEN being the match length, are written back to the
//   history one per cycle. In steady flow a token consumes LEN+1 bytes.
//   i_byte.ready is high only between tokens. A token waits in the output
//   register while the receiver stalls; the encoder goes on with the next
//   search and holds only when a second token is ready before the first
//   is taken. Reset empties history and lookahead at once; the history
//   memory has no clearing pass.
// ----------------------------------------------------------------------------
module lz77_longest_match_encoder import lzm_pkg::*; #(
    parameter int WINDOW_SIZE    = 256,
    parameter int LOOKAHEAD_SIZE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lzm_byte_if.sink           i_byte,
    lzm_token_if.source        o_token
);

    localparam int N   = LOOKAHEAD_SIZE - 1;                   // compare window
    localparam int AW  = $clog2(WINDOW_SIZE);
    localparam int HW  = $clog2(WINDOW_SIZE + 1);
    localparam int LW  = $clog2(LOOKAHEAD_SIZE);
    localparam int LFW = $clog2(LOOKAHEAD_SIZE + 1);
    localparam int JW  = $clog2(WINDOW_SIZE + LOOKAHEAD_SIZE);

    t_state r_state, n_state;

    logic [BYTE_W-1:0] r_hist [WINDOW_SIZE];
    logic [BYTE_W-1:0] r_look [LOOKAHEAD_SIZE];
    logic [BYTE_W-1:0] r_sh   [N];

    logic [HW-1:0]     r_hfill;
    logic [LFW-1:0]    r_lfill;
    logic [AW-1:0]     r_wp;
    logic              r_flush;
    logic [LW-1:0]     r_cap;
    logic [JW-1:0]     r_jmax;
    logic [JW-1:0]     r_j;
    logic [AW-1:0]     r_rd_addr;
    logic              r_d1_vld;
    logic              r_d1_hist;
    logic [JW-1:0]     r_d1_j;
    logic [BYTE_W-1:0] r_hist_q;
    logic [BYTE_W-1:0] r_la_q;
    logic              r_d2_vld;
    logic [JW-1:0]     r_d2_s;
    logic [LW-1:0]     r_best_len;
    logic [HW-1:0]     r_best_dist;
    logic [LW-1:0]     r_cnt;
    logic [BYTE_W-1:0] r_lit;

    logic              r_out_vld;
    logic [HW-1:0]     r_out_dist;
    logic [LW-1:0]     r_out_len;
    logic [BYTE_W-1:0] r_out_lit;
    logic              r_out_last;

    logic              in_acc;
    logic              search_go;
    logic              issue;
    logic              from_hist;
    logic              search_done;
    logic              out_free;
    logic              out_load;
    logic              stream_end;
    logic [AW+1:0]     base_sum;
    logic [AW-1:0]     base_addr;
    logic [BYTE_W-1:0] d1_data;
    logic [N-1:0]      ok;
    logic [LW-1:0]     m_len;
    logic [HW-1:0]     m_dist;

    assign in_acc      = i_byte.valid && i_byte.ready;
    assign search_go   = (r_hfill != '0) && (r_lfill > LFW'(1));
    assign issue       = (r_state == ST_SEARCH) && (r_j <= r_jmax);
    assign from_hist   = r_j < JW'(r_hfill);
    assign search_done = (r_j > r_jmax) && !r_d1_vld && !r_d2_vld;
    assign out_free    = !r_out_vld || o_token.ready;
    assign out_load    = (r_state == ST_EMIT) && out_free;
    assign stream_end  = r_flush && (r_lfill == '0);
    assign d1_data     = r_d1_hist ? r_hist_q : r_la_q;

    // oldest history byte sits at wp - hfill, modulo the window
    always_comb begin
        base_sum = {2'b00, r_wp} + (AW+2)'(WINDOW_SIZE) - (AW+2)'(r_hfill);
        if (base_sum >= (AW+2)'(WINDOW_SIZE)) begin
            base_sum = base_sum - (AW+2)'(WINDOW_SIZE);
        end
        base_addr = base_sum[AW-1:0];
    end

    // leading run of matching bytes in the window, capped so a literal remains
    always_comb begin
        for (int k = 0; k < N; k++) begin
            ok[k] = (r_sh[k] == r_look[k]) && (LW'(k) < r_cap);
        end
        m_len = LW'(N);
        for (int k = N - 1; k >= 0; k--) begin
            if (!ok[k]) begin
                m_len = LW'(k);
            end
        end
        m_dist = r_hfill - HW'(r_d2_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_byte.in_last || r_lfill == LFW'(LOOKAHEAD_SIZE - 1))) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = search_go ? ST_SEARCH : ST_PUSH;
            end
            ST_SEARCH: begin
                if (search_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (r_cnt == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = (r_flush && r_lfill != '0) ? ST_START : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hfill   <= '0;
            r_lfill   <= '0;
            r_wp      <= '0;
            r_flush   <= 1'b0;
            r_d1_vld  <= 1'b0;
            r_d2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_d1_vld <= issue;
            r_d2_vld <= r_d1_vld && (r_d1_j >= JW'(N - 1));
            if (in_acc) begin
                r_lfill <= r_lfill + LFW'(1);
                r_flush <= i_byte.in_last;
            end
            if (r_state == ST_PUSH) begin
                r_lfill <= r_lfill - LFW'(1);
                r_wp    <= (r_wp == AW'(WINDOW_SIZE - 1)) ? '0 : r_wp + AW'(1);
                if (r_hfill != HW'(WINDOW_SIZE)) begin
                    r_hfill <= r_hfill + HW'(1);
                end
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
                if (stream_end) begin
                    r_hfill <= '0;
                    r_wp    <= '0;
                    r_flush <= 1'b0;
                end
            end else if (o_token.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // history memory: one read port for the search, one write port for push
    always_ff @(posedge i_clk) begin
        if (issue && from_hist) begin
            r_hist_q <= r_hist[r_rd_addr];
        end
        if (r_state == ST_PUSH) begin
            r_hist[r_wp] <= r_look[0];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_look[r_lfill[LW-1:0]] <= i_byte.in_byte;
        end
        case (r_state)
            ST_START: begin
                r_cap       <= LW'(r_lfill - LFW'(1));
                r_jmax      <= JW'(r_hfill) + JW'(LOOKAHEAD_SIZE) - JW'(3);
                r_j         <= '0;
                r_rd_addr   <= base_addr;
                r_best_len  <= '0;
                r_best_dist <= '0;
                r_cnt       <= '0;
            end
            ST_SEARCH: begin
                r_cnt <= r_best_len;
            end
            ST_PUSH: begin
                for (int i = 0; i < LOOKAHEAD_SIZE - 1; i++) begin
                    r_look[i] <= r_look[i + 1];
                end
                r_cnt <= r_cnt - LW'(1);
                if (r_cnt == '0) begin
                    r_lit <= r_look[0];
                end
            end
            default: begin
            end
        endcase

        // issue stage: history bytes first, then the lookahead itself
        if (issue) begin
            r_j       <= r_j + JW'(1);
            r_d1_j    <= r_j;
            r_d1_hist <= from_hist;
            if (from_hist) begin
                r_rd_addr <= (r_rd_addr == AW'(WINDOW_SIZE - 1)) ? '0 : r_rd_addr + AW'(1);
            end else begin
                r_la_q <= r_look[LW'(r_j - JW'(r_hfill))];
            end
        end

        // compare window shifts one sequence byte per cycle
        if (r_d1_vld) begin
            for (int i = 0; i < N - 1; i++) begin
                r_sh[i] <= r_sh[i + 1];
            end
            r_sh[N-1] <= d1_data;
            r_d2_s    <= r_d1_j - JW'(N - 1);
        end

        // strictly longer wins, so the farthest-back start keeps ties
        if (r_d2_vld && (m_len > r_best_len)) begin
            r_best_len  <= m_len;
            r_best_dist <= m_dist;
        end

        if (out_load) begin
            r_out_dist <= r_best_dist;
            r_out_len  <= r_best_len;
            r_out_lit  <= r_lit;
            r_out_last <= stream_end;
        end
    end

    assign i_byte.ready           = (r_state == ST_IDLE);
    assign o_token.valid          = r_out_vld;
    assign o_token.match_distance = r_out_dist;
    assign o_token.match_length   = r_out_len;
    assign o_token.next_literal   = r_out_lit;
    assign o_token.token_last     = r_out_last;

    a_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_lfill < LFW'(LOOKAHEAD_SIZE)))
        else $error("byte accepted into a full lookahead");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) |-> (r_lfill != '0))
        else $error("consuming from an empty lookahead");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_best_len == '0) |-> (r_best_dist == '0))
        else $error("distance set without a match");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_best_len != '0)
            |-> (r_best_dist != '0 && r_best_dist <= r_hfill))
        else $error("match distance outside the history");

    a_stream_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && stream_end) |=> (r_hfill == '0 && r_wp == '0 && r_state == ST_IDLE))
        else $error("history not emptied after the final token");

endmodule

// ===== test/lzm_token_checker.sv =====
// ----------------------------------------------------------------------------
// lzm_token_checker
// Watches the byte and token channels of the LZ77 encoder. It keeps its own
// history and lookahead, works out the tokens that each accepted byte
// causes, and compares every accepted token field by field, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzm_token_checker import lzm_pkg::*; #(
    parameter int WINDOW_SIZE    = 256,
    parameter int LOOKAHEAD_SIZE = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lzm_byte_if  byte_mon,
    lzm_token_if tok_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int DIST_W    = 9;
    localparam int LEN_W     = 4;
    localparam int MAX_PRINT = 100;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] literal;
        logic              last;
    } t_token;

    logic [BYTE_W-1:0] window_mem [WINDOW_SIZE];
    logic [BYTE_W-1:0] ahead_mem  [LOOKAHEAD_SIZE];
    int                window_fill;
    int                ahead_fill;
    int                window_wr;
    t_token            expected_tokens [$];
    int                token_index;

    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_PRINT) begin
            $display("%0t checker: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    // longest match over every history start, oldest start wins a tie;
    // the consumed bytes move from the lookahead into the history
    task automatic encode_token(output t_token tok);
        int                cap;
        int                best_len;
        int                best_dist;
        int                s;
        int                k;
        int                j;
        int                i;
        logic [BYTE_W-1:0] c;
        cap       = ahead_fill - 1;
        best_len  = 0;
        best_dist = 0;
        for (s = 0; s < window_fill; s++) begin
            k = 0;
            while (k < cap) begin
                j = s + k;
                // the match may run on from the history into the lookahead
                if (j < window_fill) begin
                    c = window_mem[(window_wr + WINDOW_SIZE - window_fill + j) % WINDOW_SIZE];
                end else begin
                    c = ahead_mem[j - window_fill];
                end
                if (c != ahead_mem[k]) break;
                k++;
            end
            if (k > best_len) begin
                best_len  = k;
                best_dist = window_fill - s;
            end
        end
        tok.distance = DIST_W'(best_dist);
        tok.length   = LEN_W'(best_len);
        tok.literal  = ahead_mem[best_len];
        tok.last     = 1'b0;
        for (i = 0; i <= best_len; i++) begin
            window_mem[window_wr] = ahead_mem[i];
            window_wr = (window_wr + 1) % WINDOW_SIZE;
            if (window_fill < WINDOW_SIZE) window_fill++;
        end
        for (i = 0; i < ahead_fill - best_len - 1; i++) begin
            ahead_mem[i] = ahead_mem[i + best_len + 1];
        end
        ahead_fill -= best_len + 1;
    endtask

    always @(posedge i_clk) begin : monitor
        t_token tok;
        t_token want;
        if (!i_rst_n) begin
            window_fill  = 0;
            ahead_fill   = 0;
            window_wr    = 0;
            token_index  = 0;
            o_fail_count = 0;
            expected_tokens.delete();
        end else begin
            if (byte_mon.valid && byte_mon.ready) begin
                if (ahead_fill < LOOKAHEAD_SIZE) begin
                    ahead_mem[ahead_fill] = byte_mon.in_byte;
                    ahead_fill++;
                end
                if (!byte_mon.in_last) begin
                    if (ahead_fill >= LOOKAHEAD_SIZE) begin
                        encode_token(tok);
                        expected_tokens.push_back(tok);
                    end
                end else begin
                    // flush: drain the lookahead, then the next word opens a new stream
                    while (ahead_fill > 0) begin
                        encode_token(tok);
                        tok.last = (ahead_fill == 0);
                        expected_tokens.push_back(tok);
                    end
                    window_fill = 0;
                    ahead_fill  = 0;
                    window_wr   = 0;
                end
            end
            if (tok_mon.valid && tok_mon.ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch($sformatf(
                        "token %0d: none expected (dist %0d len %0d lit 0x%02h last %0b)",
                        token_index, tok_mon.match_distance, tok_mon.match_length,
                        tok_mon.next_literal, tok_mon.token_last));
                end else begin
                    want = expected_tokens.pop_front();
                    if (tok_mon.match_distance !== want.distance) begin
                        report_mismatch($sformatf("token %0d: distance %0d, expected %0d",
                            token_index, tok_mon.match_distance, want.distance));
                    end
                    if (tok_mon.match_length !== want.length) begin
                        report_mismatch($sformatf("token %0d: length %0d, expected %0d",
                            token_index, tok_mon.match_length, want.length));
                    end
                    if (tok_mon.next_literal !== want.literal) begin
                        report_mismatch($sformatf("token %0d: literal 0x%02h, expected 0x%02h",
                            token_index, tok_mon.next_literal, want.literal));
                    end
                    if (tok_mon.token_last !== want.last) begin
                        report_mismatch($sformatf("token %0d: last %0b, expected %0b",
                            token_index, tok_mon.token_last, want.last));
                    end
                end
                token_index++;
            end
        end
        o_pending = expected_tokens.size();
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives byte streams into the LZ77 encoder: a few directed streams, then
// random streams of random, small-alphabet and self-copying content, with
// bursty input, a stalling token receiver and one long receiver hold-off.
// The checker beside the block predicts and compares every token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import lzm_pkg::*;

    localparam int WINDOW_SIZE    = 256;
    localparam int LOOKAHEAD_SIZE = 16;
    localparam int TARGET_BYTES   = 460;
    localparam int LONG_STREAM    = 280;
    localparam int HOLD_CYCLES    = 3000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int TIMEOUT_NS     = 10_000_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    bit   hold_req   = 1'b0;
    int   burst_left = 0;

    lzm_byte_if  byte_if ();
    lzm_token_if tok_if ();

    lz77_longest_match_encoder #(
        .WINDOW_SIZE    (WINDOW_SIZE),
        .LOOKAHEAD_SIZE (LOOKAHEAD_SIZE)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_token (tok_if)
    );

    lzm_token_checker #(
        .WINDOW_SIZE    (WINDOW_SIZE),
        .LOOKAHEAD_SIZE (LOOKAHEAD_SIZE)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .byte_mon     (byte_if),
        .tok_mon      (tok_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("lz77_longest_match_encoder: mismatch");
        $finish;
    end

    // offer one word and wait until it is taken; gaps fall between bursts
    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 4) == 0) ? 400 : 30);
            if (gap > 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        byte_if.valid   <= 1'b1;
        byte_if.in_byte <= b;
        byte_if.in_last <= last;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        burst_left--;
    endtask

    // mode 0: any byte, 1: small alphabet, 2: copies of earlier runs
    task automatic send_stream(input int len, input int mode);
        logic [BYTE_W-1:0] seen [$];
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] b;
        int                run_left;
        int                run_dist;
        int                i;
        base     = BYTE_W'($urandom);
        run_left = 0;
        run_dist = 1;
        for (i = 0; i < len; i++) begin
            if (mode == 0) begin
                b = BYTE_W'($urandom);
            end else if (mode == 1) begin
                b = base + BYTE_W'($urandom_range(0, 2));
            end else begin
                if (run_left == 0 && seen.size() > 0 && $urandom_range(0, 3) != 0) begin
                    run_left = $urandom_range(1, 20);
                    run_dist = $urandom_range(1,
                        (seen.size() > WINDOW_SIZE) ? WINDOW_SIZE : seen.size());
                end
                if (run_left > 0) begin
                    b = seen[seen.size() - run_dist];
                    run_left--;
                end else begin
                    b = BYTE_W'($urandom);
                end
            end
            seen.push_back(b);
            put_byte(b, i == len - 1);
        end
    endtask

    initial begin : token_sink
        int mode;
        int seg_left;
        bit hold_done;
        tok_if.ready = 1'b0;
        mode      = 0;
        seg_left  = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                // long hold-off: the block fills up and stops taking words
                hold_done = 1'b1;
                tok_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(20, 400);
                end
                seg_left--;
                case (mode)
                    0: begin
                        tok_if.ready <= 1'b1;
                    end
                    1: begin
                        tok_if.ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        tok_if.ready <= ($urandom_range(0, 7) == 0);
                    end
                    default: begin
                        tok_if.ready <= ((seg_left % 6) < 3);
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        int total;
        int len;
        int i;
        byte_if.valid   = 1'b0;
        byte_if.in_byte = '0;
        byte_if.in_last = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-byte streams at both byte extremes
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b1);
        // a run of one value: the match runs on into the lookahead at full length
        for (i = 0; i < 18; i++) begin
            put_byte(8'h5A, i == 17);
        end
        // short flush with a back-reference
        put_byte(8'h01, 1'b0);
        put_byte(8'h02, 1'b0);
        put_byte(8'h01, 1'b0);
        put_byte(8'h02, 1'b1);
        total = 24;

        // a stream past the window length, under a long receiver hold-off
        hold_req = 1'b1;
        send_stream(LONG_STREAM, 2);
        total += LONG_STREAM;

        while (total < TARGET_BYTES) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
            if (len > TARGET_BYTES - total) begin
                len = TARGET_BYTES - total;
            end
            send_stream(len, $urandom_range(0, 2));
            total += len;
        end
        byte_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("lz77_longest_match_encoder: match");
        end else begin
            $display("lz77_longest_match_encoder: mismatch");
        end
        $finish;
    end

endmodule
